// ===== hdl/bdfg_pkg.sv =====
// Package: shared constants, job record and helper functions for the battery display generator.
`timescale 1ns / 1ps
package bdfg_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hC5;
    localparam logic [7:0] CMD_SWITCH = 8'h01;
    localparam logic [7:0] CMD_DIGITS = 8'h02;
    localparam logic [7:0] CMD_MARKS  = 8'h03;
    localparam logic [7:0] SWITCH_ON  = 8'h01;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_WARNING = 2'd1;
    localparam logic [1:0] MODE_TESTING = 2'd2;

    localparam logic       REG_DISPLAY_MODE  = 1'b0;
    localparam logic       REG_TOGGLE_PERIOD = 1'b1;

    localparam logic [1:0] DISPLAY_MODE_RESET  = MODE_NORMAL;
    localparam logic [7:0] TOGGLE_PERIOD_RESET = 8'd10;

    localparam logic [7:0]  PCT_LIMIT   = 8'd100;
    localparam logic [15:0] VOLT_LIMIT  = 16'd600;
    localparam logic [7:0]  BAR_DIV     = 8'd13;
    localparam logic [3:0]  BAR_MAX     = 4'd8;
    localparam logic [3:0]  DIGIT_ALL   = 4'd8;

    localparam logic [17:0] MARKS_ALL     = 18'h3FFFF;
    localparam logic [17:0] MARK_BATTERY  = 18'h04000;
    localparam logic [17:0] MARK_PERCENT  = 18'h00020;
    localparam logic [17:0] MARK_VOLT     = 18'h00010;
    localparam logic [17:0] MARK_DECIMAL  = 18'h10000;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int FRAME_BYTES     = 16;

    typedef struct packed {
        logic [3:0]  d0;
        logic [3:0]  d1;
        logic [3:0]  d2;
        logic [17:0] marks;
    } job_t;

    // Three decimal digits of a value no larger than 999.
    function automatic logic [11:0] to_digits(input logic [9:0] v);
        logic [3:0] h;
        logic [3:0] t;
        logic [9:0] r;
        logic [9:0] o;
        h = 4'd0;
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= 10'(k * 100))
                h = 4'(k);
        end
        r = v - 10'(h) * 10'd100;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 10'(k * 10))
                t = 4'(k);
        end
        o = r - 10'(t) * 10'd10;
        return {h, t, o[3:0]};
    endfunction

    // pct / 13 + 1, capped at 8.
    function automatic logic [3:0] bar_step(input logic [7:0] pct);
        logic [3:0] s;
        s = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if (pct >= 8'(k * BAR_DIV))
                s = 4'(k + 1);
        end
        return s;
    endfunction

    function automatic logic [17:0] bar_marks(input logic [3:0] step);
        logic [7:0] seg;
        seg = 8'((9'd1 << step) - 9'd1);
        return MARK_BATTERY | (18'(seg) << 6);
    endfunction

endpackage

// ===== hdl/bdfg_if.sv =====
// Interfaces: tick input channel and serial byte output channel.
`timescale 1ns / 1ps
interface bdfg_tick_if;
    logic        valid;
    logic        ready;
    logic [7:0]  charge_percent;
    logic [15:0] volt_tenths;
    logic        charging;

    modport source (output valid, charge_percent, volt_tenths, charging, input ready);
    modport sink   (input valid, charge_percent, volt_tenths, charging, output ready);
endinterface

interface bdfg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;
    logic       last;

    modport source (output valid, tx_byte, frame_end, last, input ready);
    modport sink   (input valid, tx_byte, frame_end, last, output ready);
endinterface

// ===== hdl/bdfg_front.sv =====
// Front end: config registers, per-tick state update and job classification.
`timescale 1ns / 1ps
module bdfg_front
    import bdfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    bdfg_tick_if.sink   tick,
    input  logic        job_ready,
    output logic        job_valid,
    output job_t        job
);

    logic [1:0] display_mode_reg;
    logic [7:0] toggle_period_reg;
    logic [7:0] alt_counter_reg, alt_counter_next;
    logic       show_percent_reg, show_percent_next;
    logic [3:0] anim_step_reg, anim_step_next;

    logic        accept;
    logic        normal;
    logic [7:0]  alt_inc;
    logic [3:0]  step;
    logic [3:0]  anim_inc;
    logic [3:0]  shown_step;
    logic        over;
    logic [9:0]  value;
    logic [11:0] digits;
    logic [17:0] marks;

    assign tick.ready = job_ready;
    assign accept     = tick.valid && tick.ready;
    assign normal     = (display_mode_reg == MODE_NORMAL);

    always_comb
    begin
        alt_inc           = alt_counter_reg + 8'd1;
        alt_counter_next  = alt_inc;
        show_percent_next = show_percent_reg;
        if (alt_inc >= toggle_period_reg)
        begin
            alt_counter_next  = 8'd0;
            show_percent_next = !show_percent_reg;
        end

        step           = bar_step(tick.charge_percent);
        anim_inc       = anim_step_reg + 4'd1;
        anim_step_next = anim_step_reg;
        shown_step     = step;
        if (tick.charging)
        begin
            anim_step_next = (anim_inc > step) ? 4'd0 : anim_inc;
            shown_step     = anim_step_next;
        end

        if (show_percent_next)
        begin
            over  = tick.charge_percent > PCT_LIMIT;
            value = 10'(tick.charge_percent);
            marks = bar_marks(shown_step) | MARK_PERCENT;
        end
        else
        begin
            over  = tick.volt_tenths > VOLT_LIMIT;
            value = tick.volt_tenths[9:0];
            marks = bar_marks(shown_step) | MARK_VOLT | MARK_DECIMAL;
        end
        digits = to_digits(value);

        job = '{d0: digits[11:8], d1: digits[7:4], d2: digits[3:0], marks: marks};
        if (over)
        begin
            job.d0 = DIGIT_ALL;
            job.d1 = DIGIT_ALL;
            job.d2 = DIGIT_ALL;
        end
        if (display_mode_reg == MODE_TESTING)
            job = '{d0: DIGIT_ALL, d1: DIGIT_ALL, d2: DIGIT_ALL, marks: MARKS_ALL};
    end

    assign job_valid = tick.valid &&
                       (display_mode_reg == MODE_NORMAL || display_mode_reg == MODE_TESTING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_mode_reg  <= DISPLAY_MODE_RESET;
            toggle_period_reg <= TOGGLE_PERIOD_RESET;
            alt_counter_reg   <= '0;
            show_percent_reg  <= 1'b0;
            anim_step_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_DISPLAY_MODE)
                display_mode_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == REG_TOGGLE_PERIOD)
                toggle_period_reg <= cfg_data;
            if (accept && normal)
            begin
                alt_counter_reg  <= alt_counter_next;
                show_percent_reg <= show_percent_next;
                anim_step_reg    <= anim_step_next;
            end
        end
    end

endmodule

// ===== hdl/bdfg_queue.sv =====
// Job queue between front and back end.
`timescale 1ns / 1ps
module bdfg_queue
    import bdfg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          store [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

// ===== hdl/bdfg_back.sv =====
// Back end: walks one job into sixteen frame bytes behind an output register.
`timescale 1ns / 1ps
module bdfg_back
    import bdfg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    bdfg_byte_if.source tx
);

    localparam int IW = $clog2(FRAME_BYTES);

    logic [IW-1:0] idx_reg;
    logic          out_valid_reg;
    logic [7:0]    tx_byte_reg;
    logic          frame_end_reg;
    logic          last_reg;

    logic       load;
    logic [7:0] b0, b1, b2;
    logic [7:0] digit_sum, marks_sum;
    logic [7:0] byte_sel;
    logic       end_sel;

    assign load    = job_valid && (!out_valid_reg || tx.ready);
    assign job_pop = load && (idx_reg == IW'(FRAME_BYTES - 1));

    assign b0 = job.marks[7:0];
    assign b1 = job.marks[15:8];
    assign b2 = 8'(job.marks[17:16]);
    assign digit_sum = CMD_DIGITS + 8'(job.d0) + 8'(job.d1) + 8'(job.d2);
    assign marks_sum = CMD_MARKS + b0 + b1 + b2;

    always_comb
    begin
        end_sel = 1'b0;
        case (idx_reg)
            4'd0:    byte_sel = HDR_BYTE;
            4'd1:    byte_sel = CMD_SWITCH;
            4'd2:    byte_sel = SWITCH_ON;
            4'd3:
            begin
                byte_sel = CMD_SWITCH + SWITCH_ON;
                end_sel  = 1'b1;
            end
            4'd4:    byte_sel = HDR_BYTE;
            4'd5:    byte_sel = CMD_DIGITS;
            4'd6:    byte_sel = 8'(job.d0);
            4'd7:    byte_sel = 8'(job.d1);
            4'd8:    byte_sel = 8'(job.d2);
            4'd9:
            begin
                byte_sel = digit_sum;
                end_sel  = 1'b1;
            end
            4'd10:   byte_sel = HDR_BYTE;
            4'd11:   byte_sel = CMD_MARKS;
            4'd12:   byte_sel = b0;
            4'd13:   byte_sel = b1;
            4'd14:   byte_sel = b2;
            default:
            begin
                byte_sel = marks_sum;
                end_sel  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg   <= byte_sel;
            frame_end_reg <= end_sel;
            last_reg      <= (idx_reg == IW'(FRAME_BYTES - 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= idx_reg + IW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (tx.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign tx.valid     = out_valid_reg;
    assign tx.tx_byte   = tx_byte_reg;
    assign tx.frame_end = frame_end_reg;
    assign tx.last      = last_reg;

    a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.last |-> tx.frame_end)
        else $error("last byte does not close a frame");

    a_tick_starts_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        load && idx_reg == '0 |=> tx_byte_reg == HDR_BYTE && !last_reg)
        else $error("tick does not start with a header");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> tx.valid && tx.last && idx_reg == '0)
        else $error("job released before its final byte");

endmodule

// ===== hdl/battery_display_frame_generator_top.sv =====
// Top level of the battery display frame generator.
//
//  channel  dir  payload                                      transfer
//  tick     in   charge_percent[7:0] volt_tenths[15:0] charging  valid & ready
//  tx       out  tx_byte[7:0] frame_end last                  valid & ready
//  cfg      in   cfg_index[0] cfg_data[7:0]                   cfg_we
//
// A normal or testing tick yields 16 bytes; the back end byte sequencer sends them
// one per cycle while the output is ready. A warning tick is taken while the queue
// has room and yields nothing. The front takes a tick while the queue has room, so
// QUEUE_DEPTH - 1 ticks can wait while one is sent. Output stalls hold the output
// register and back up through the queue. Reset is asynchronous, no clearing pass.
`timescale 1ns / 1ps
module battery_display_frame_generator_top
    import bdfg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    bdfg_tick_if.sink   tick,
    bdfg_byte_if.source tx
);

    logic job_valid;
    logic push;
    logic not_full;
    logic not_empty;
    logic pop;
    job_t job_in;
    job_t job_head;

    bdfg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .job_ready (not_full),
        .job_valid (job_valid),
        .job       (job_in)
    );

    assign push = job_valid && not_full;

    bdfg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (job_in),
        .not_full  (not_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (job_head)
    );

    bdfg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (job_head),
        .job_pop   (pop),
        .tx        (tx)
    );

endmodule
